FILE: design/prrs_pkg.sv
// package for the priority round-robin scheduler
// sizes, request and status codes; no dependencies
package prrs_pkg;
  localparam int NUM_THREADS = 64;
  localparam int NUM_LEVELS  = 16;
  localparam int TW = $clog2(NUM_THREADS);
  localparam int LW = $clog2(NUM_LEVELS);

  typedef logic [TW-1:0] thr_t;
  typedef logic [LW-1:0] lvl_t;

  typedef enum logic [1:0] {
    REQ_PUSH  = 2'd0,
    REQ_PULL  = 2'd1,
    REQ_SCHED = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NOT_THREAD = 2'd1,
    ST_QUEUED     = 2'd2,
    ST_NOT_QUEUED = 2'd3
  } status_t;
endpackage

FILE: design/priority_round_robin_scheduler.sv
// priority round-robin scheduler, link tables in synchronous memories
// depends on prrs_pkg
//
// Usage: requests come in on in_valid/in_ready with req_type, thread_id,
// priority_req and is_thread_object. Each request gives exactly one result
// on out_valid/out_ready: status, current_thread (0 while idle) and idle.
// A request is taken only when the sequencer is idle; it runs as a short
// read-modify-write sequence over the link and ring memories, with one read
// and one write port per table and registered read data. States in order:
//   error, unused code, schedule while idle, push to an empty ring:
//   dispatch, done; schedule: dispatch, sched, done; push to a ring:
//   dispatch, push_l1, push_l2, done; pull: dispatch, pull_rd, pull_ex,
//   pull_hd when a new ring head must be fetched, done; then back to idle.
// The result sits in an output register; if the receiver stalls, the next
// request can run but its result waits until the register is free.
// Reset (rst, synchronous) clears all queued bits, the occupied mask and
// the running thread, and sets idle; link memories need no clearing.
module priority_round_robin_scheduler (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       req_type,
  input  prrs_pkg::thr_t   thread_id,
  input  prrs_pkg::lvl_t   priority_req,
  input  logic             is_thread_object,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [1:0]       status,
  output prrs_pkg::thr_t   current_thread,
  output logic             idle
);
  import prrs_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_DISPATCH = 9'b000000010,
    S_SCHED    = 9'b000000100,
    S_PUSH_L1  = 9'b000001000,
    S_PUSH_L2  = 9'b000010000,
    S_PULL_RD  = 9'b000100000,
    S_PULL_EX  = 9'b001000000,
    S_PULL_HD  = 9'b010000000,
    S_DONE     = 9'b100000000
  } state_t;

  state_t state, state_next;

  // memories
  thr_t next_mem [NUM_THREADS];
  thr_t prev_mem [NUM_THREADS];
  lvl_t lvl_mem  [NUM_THREADS];
  thr_t head_mem [NUM_LEVELS];
  thr_t tail_mem [NUM_LEVELS];

  thr_t next_rd, prev_rd, head_rd, tail_rd;
  lvl_t lvl_rd;
  thr_t next_ra, next_wa, next_wd, prev_wa, prev_wd;
  logic next_we, prev_we, lvl_we, head_we, tail_we;
  lvl_t ring_ra, ring_wa;
  thr_t head_wd, tail_wd;

  // control registers
  logic [NUM_THREADS-1:0] queued;
  logic [NUM_LEVELS-1:0]  occ;
  thr_t    running_thread;
  lvl_t    running_level;
  logic    idle_flag;

  // request and working registers
  req_t    req_r;
  thr_t    t_r;
  lvl_t    pl_r;
  logic    isth_r;
  status_t st_r;
  thr_t    nx_r, pv_r, h_r, tl_r;
  lvl_t    lv_r;

  logic [NUM_LEVELS-1:0] higher_mask;
  logic [NUM_LEVELS-1:0] occ_cleared;
  logic                  found;
  lvl_t                  found_idx;
  logic                  out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;
  assign higher_mask = (NUM_LEVELS'(1) << pl_r) - NUM_LEVELS'(1);
  assign occ_cleared = occ & ~(NUM_LEVELS'(1) << lv_r);

  always_comb begin
    found = 1'b0;
    found_idx = '0;
    for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
      if (occ_cleared[i]) begin
        found = 1'b1;
        found_idx = LW'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (next_we) next_mem[next_wa] <= next_wd;
    if (prev_we) prev_mem[prev_wa] <= prev_wd;
    if (lvl_we) lvl_mem[t_r] <= pl_r;
    if (head_we) head_mem[ring_wa] <= head_wd;
    if (tail_we) tail_mem[ring_wa] <= tail_wd;
    next_rd <= next_mem[next_ra];
    prev_rd <= prev_mem[t_r];
    lvl_rd  <= lvl_mem[t_r];
    head_rd <= head_mem[ring_ra];
    tail_rd <= tail_mem[ring_ra];
  end

  // memory addressing and writes
  always_comb begin
    next_ra = (req_r == REQ_SCHED) ? running_thread : t_r;
    next_we = 1'b0;
    next_wa = t_r;
    next_wd = t_r;
    prev_we = 1'b0;
    prev_wa = t_r;
    prev_wd = t_r;
    lvl_we  = 1'b0;
    head_we = 1'b0;
    tail_we = 1'b0;
    ring_wa = pl_r;
    head_wd = t_r;
    tail_wd = t_r;
    ring_ra = pl_r;
    case (state)
      S_DISPATCH: begin
        if (req_r == REQ_PUSH && isth_r && !queued[t_r] && !occ[pl_r]) begin
          next_we = 1'b1;
          prev_we = 1'b1;
          lvl_we  = 1'b1;
          head_we = 1'b1;
          tail_we = 1'b1;
        end else if (req_r == REQ_PUSH && isth_r && !queued[t_r]) begin
          lvl_we = 1'b1;
        end
      end
      S_PUSH_L1: begin
        next_we = 1'b1;
        next_wd = head_rd;
        prev_we = 1'b1;
        prev_wd = tail_rd;
        tail_we = 1'b1;
      end
      S_PUSH_L2: begin
        next_we = 1'b1;
        next_wa = tl_r;
        prev_we = 1'b1;
        prev_wa = h_r;
      end
      S_PULL_RD: begin
        ring_ra = lvl_rd;
      end
      S_PULL_EX: begin
        ring_ra = found_idx;
        ring_wa = lv_r;
        if (!(head_rd == t_r && tail_rd == t_r)) begin
          head_we = (head_rd == t_r);
          head_wd = nx_r;
          tail_we = (tail_rd == t_r);
          tail_wd = pv_r;
          next_we = 1'b1;
          next_wa = pv_r;
          next_wd = nx_r;
          prev_we = 1'b1;
          prev_wa = nx_r;
          prev_wd = pv_r;
        end
      end
      default: ;
    endcase
  end

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_valid) state_next = S_DISPATCH;
      S_DISPATCH: begin
        state_next = S_DONE;
        if (req_r == REQ_SCHED && !idle_flag) begin
          state_next = S_SCHED;
        end else if (req_r == REQ_PUSH && isth_r && !queued[t_r] && occ[pl_r]) begin
          state_next = S_PUSH_L1;
        end else if (req_r == REQ_PULL && isth_r && queued[t_r]) begin
          state_next = S_PULL_RD;
        end
      end
      S_SCHED:   state_next = S_DONE;
      S_PUSH_L1: state_next = S_PUSH_L2;
      S_PUSH_L2: state_next = S_DONE;
      S_PULL_RD: state_next = S_PULL_EX;
      S_PULL_EX: begin
        if (head_rd == t_r && tail_rd == t_r && !idle_flag && running_level == lv_r
            && found) begin
          state_next = S_PULL_HD;
        end else begin
          state_next = S_DONE;
        end
      end
      S_PULL_HD: state_next = S_DONE;
      S_DONE:    if (out_free) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      queued         <= '0;
      occ            <= '0;
      running_thread <= '0;
      running_level  <= '0;
      idle_flag      <= 1'b1;
      out_valid      <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_DISPATCH: begin
          if ((req_r == REQ_PUSH || req_r == REQ_PULL) && !isth_r) begin
            st_r <= ST_NOT_THREAD;
          end else if (req_r == REQ_PUSH && queued[t_r]) begin
            st_r <= ST_QUEUED;
          end else if (req_r == REQ_PULL && !queued[t_r]) begin
            st_r <= ST_NOT_QUEUED;
          end else begin
            st_r <= ST_OK;
            if (req_r == REQ_PUSH) begin
              queued[t_r] <= 1'b1;
              if (!occ[pl_r]) begin
                occ[pl_r] <= 1'b1;
                if ((occ & higher_mask) == '0) begin
                  running_thread <= t_r;
                  running_level  <= pl_r;
                  idle_flag      <= 1'b0;
                end
              end
            end
          end
        end
        S_SCHED: running_thread <= next_rd;
        S_PUSH_L1: begin
          h_r  <= head_rd;
          tl_r <= tail_rd;
        end
        S_PULL_RD: begin
          nx_r <= next_rd;
          pv_r <= prev_rd;
          lv_r <= lvl_rd;
        end
        S_PULL_EX: begin
          queued[t_r] <= 1'b0;
          if (head_rd == t_r && tail_rd == t_r) begin
            occ[lv_r] <= 1'b0;
            if (!idle_flag && running_level == lv_r) begin
              if (found) begin
                running_level <= found_idx;
              end else begin
                idle_flag      <= 1'b1;
                running_thread <= '0;
                running_level  <= '0;
              end
            end
          end else if (!idle_flag && running_thread == t_r) begin
            running_thread <= nx_r;
          end
        end
        S_PULL_HD: running_thread <= head_rd;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      req_r  <= req_t'(req_type);
      t_r    <= thread_id;
      pl_r   <= priority_req;
      isth_r <= is_thread_object;
    end
    if (state == S_DONE && out_free) begin
      status         <= st_r;
      current_thread <= idle_flag ? '0 : running_thread;
      idle           <= idle_flag;
    end
  end

`ifndef ASSERT_OFF
  a_run_occ: assert property (@(posedge clk) disable iff (rst)
    !idle_flag && state == S_IDLE |-> occ[running_level])
    else $error("running level not occupied");
  a_run_queued: assert property (@(posedge clk) disable iff (rst)
    !idle_flag && state == S_IDLE |-> queued[running_thread])
    else $error("running thread not queued");
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    idle_flag && state == S_IDLE |-> occ == '0)
    else $error("idle with occupied ring");
  a_higher_empty: assert property (@(posedge clk) disable iff (rst)
    !idle_flag && state == S_IDLE |->
      (occ & ((NUM_LEVELS'(1) << running_level) - NUM_LEVELS'(1))) == '0)
    else $error("higher ring occupied than running one");
  a_accept_seq: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == S_DISPATCH)
    else $error("request accepted without dispatch");
`endif
endmodule
